@@ hw/rtl/ffpa_pkg.sv @@
`default_nettype none

package ffpa_pkg;

  // Table geometry.
  localparam int MAX_BLOCKS = 64;
  localparam int NUM_PAGES  = 32768;
  localparam int ADDR_W     = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int START_W    = $clog2(NUM_PAGES);
  localparam int LEN_W      = START_W + 1;

  // Request codes.
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_NOFIT = 2'd1;
  localparam logic [1:0] STS_ZERO  = 2'd2;
  localparam logic [1:0] STS_FULL  = 2'd3;

  // One free block as stored in the table.
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } ffpa_entry_t;

  // Operands of the shared arithmetic unit.
  typedef struct packed {
    logic [LEN_W-1:0]   a;
    logic [LEN_W-1:0]   b;
    logic [START_W-1:0] c;
  } ffpa_alu_in_t;

  // Results of the shared arithmetic unit.
  typedef struct packed {
    logic [LEN_W:0]   sum;
    logic [LEN_W-1:0] sat;
    logic [LEN_W-1:0] diff;
    logic             ge;
    logic             eq;
  } ffpa_alu_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/first_fit_page_allocator_core.sv @@
`default_nettype none

// First-fit page allocator. Free page blocks live in a 64-entry table sorted
// by start page, next to a running total of free pages. Each input item is an
// allocate, a free or an add-region request and yields exactly one result item
// with a status, the start page of an allocated block and the free total after
// the request. Allocate takes the first block that is long enough and keeps
// any remainder in place; free merges with adjacent neighbors; add region only
// inserts. The table sits in a single-port-read, single-port-write memory with
// registered read data, and one shared adder/subtractor does the page and
// length arithmetic. The idle state takes the item in. The search then reads
// one entry per cycle and stops at the first fitting block or at the insertion
// slot. An insert or a removal moves the entries above that slot by one. Free
// and add then pass the merge checks in ST_MLO, ST_MLEN, ST_MHI, ST_MHLEN and
// ST_COMMIT, and the done state loads the output register; requests rejected
// up front go straight to the done state. The input is not ready while an item
// is in work. A finished result sits in an output register, so the next item
// is taken while it waits.
module first_fit_page_allocator_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [1:0]                   in_op,
  input  wire  [ffpa_pkg::START_W-1:0] in_page_index,
  input  wire  [ffpa_pkg::LEN_W-1:0]   in_page_count,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   out_status,
  output logic [ffpa_pkg::START_W-1:0] out_alloc_start,
  output logic [ffpa_pkg::LEN_W-1:0]   out_free_total
);
  import ffpa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALC,
    ST_ALC2,
    ST_MLO,
    ST_MLEN,
    ST_MHI,
    ST_MHLEN,
    ST_COMMIT,
    ST_SHUP,
    ST_SHDN,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [START_W-1:0] base_r, base_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [LEN_W-1:0]   free_total_r, free_total_nxt;
  logic [LEN_W-1:0]   tot_dec_r, tot_dec_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [START_W-1:0] astart_r, astart_nxt;
  logic [CNT_W-1:0]   rp_r, rp_nxt;
  logic [CNT_W-1:0]   wp_r, wp_nxt;
  logic               dv_r, dv_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               has_lo_r, has_lo_nxt;
  logic               has_hi_r, has_hi_nxt;
  ffpa_entry_t        lo_r, lo_nxt;
  ffpa_entry_t        hi_r, hi_nxt;
  ffpa_entry_t        found_r, found_nxt;
  logic [LEN_W-1:0]   len_new_r, len_new_nxt;
  logic               mlo_r, mlo_nxt;
  logic               mhi_r, mhi_nxt;
  logic [START_W-1:0] seg_start_r, seg_start_nxt;
  logic [LEN_W-1:0]   seg_len_r, seg_len_nxt;
  logic [LEN_W-1:0]   mlen_r, mlen_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [START_W-1:0] out_alloc_start_r, out_alloc_start_nxt;
  logic [LEN_W-1:0]   out_free_total_r, out_free_total_nxt;

  // Block table and its ports.
  ffpa_entry_t        tbl_mem [MAX_BLOCKS];
  ffpa_entry_t        rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  ffpa_entry_t        wr_data;

  ffpa_alu_in_t       alu_in;
  ffpa_alu_out_t      alu_out;

  // Index arithmetic used by the sequencer.
  logic [CNT_W-1:0]   rp_dec;
  logic [CNT_W-1:0]   idx_dec;
  logic [CNT_W-1:0]   idx_inc;

  assign rp_dec  = rp_r - CNT_W'(1);
  assign idx_dec = idx_r - CNT_W'(1);
  assign idx_inc = idx_r + CNT_W'(1);

  ffpa_alu u_alu (
    .alu_in  (alu_in),
    .alu_out (alu_out)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_alloc_start = out_alloc_start_r;
  assign out_free_total  = out_free_total_r;

  always_comb begin
    logic stop;
    stop                = 1'b0;
    state_nxt           = state_r;
    op_nxt              = op_r;
    base_nxt            = base_r;
    cnt_nxt             = cnt_r;
    count_nxt           = count_r;
    free_total_nxt      = free_total_r;
    tot_dec_nxt         = tot_dec_r;
    status_nxt          = status_r;
    astart_nxt          = astart_r;
    rp_nxt              = rp_r;
    wp_nxt              = wp_r;
    dv_nxt              = dv_r;
    idx_nxt             = idx_r;
    has_lo_nxt          = has_lo_r;
    has_hi_nxt          = has_hi_r;
    lo_nxt              = lo_r;
    hi_nxt              = hi_r;
    found_nxt           = found_r;
    len_new_nxt         = len_new_r;
    mlo_nxt             = mlo_r;
    mhi_nxt             = mhi_r;
    seg_start_nxt       = seg_start_r;
    seg_len_nxt         = seg_len_r;
    mlen_nxt            = mlen_r;
    out_valid_nxt       = out_valid_r;
    out_status_nxt      = out_status_r;
    out_alloc_start_nxt = out_alloc_start_r;
    out_free_total_nxt  = out_free_total_r;
    rd_addr             = '0;
    wr_en               = 1'b0;
    wr_addr             = '0;
    wr_data             = '0;
    alu_in.a            = free_total_r;
    alu_in.b            = cnt_r;
    alu_in.c            = base_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        // Both the decremented and the saturated total come from one pass.
        alu_in.a = free_total_r;
        alu_in.b = in_page_count;
        if (in_valid) begin
          op_nxt      = in_op;
          base_nxt    = in_page_index;
          cnt_nxt     = in_page_count;
          tot_dec_nxt = alu_out.diff;
          has_lo_nxt  = 1'b0;
          has_hi_nxt  = 1'b0;
          astart_nxt  = '0;
          status_nxt  = STS_OK;
          rp_nxt      = '0;
          dv_nxt      = 1'b0;
          if (in_op != OP_ALLOC && in_op != OP_FREE && in_op != OP_ADD) begin
            state_nxt = ST_DONE;
          end else if (in_page_count == '0) begin
            status_nxt = STS_ZERO;
            state_nxt  = ST_DONE;
          end else if (in_op == OP_ALLOC) begin
            if (!alu_out.ge) begin
              status_nxt = STS_NOFIT;
              state_nxt  = ST_DONE;
            end else begin
              state_nxt = ST_SCAN;
            end
          end else if (count_r == CNT_W'(MAX_BLOCKS)) begin
            status_nxt = STS_FULL;
            state_nxt  = ST_DONE;
          end else begin
            free_total_nxt = alu_out.sat;
            state_nxt      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // One entry is read per cycle; the entry read last cycle is tested.
        if (op_r == OP_ALLOC) begin
          alu_in.a = rd_data_r.len;
          alu_in.b = cnt_r;
        end else begin
          alu_in.a = {1'b0, base_r};
          alu_in.b = {1'b0, rd_data_r.start};
        end
        if (dv_r) begin
          if (op_r == OP_ALLOC) begin
            if (alu_out.ge) begin
              found_nxt = rd_data_r;
              idx_nxt   = rp_dec;
              stop      = 1'b1;
              state_nxt = ST_ALC;
            end
          end else if (alu_out.ge) begin
            lo_nxt     = rd_data_r;
            has_lo_nxt = 1'b1;
          end else begin
            hi_nxt     = rd_data_r;
            has_hi_nxt = 1'b1;
            idx_nxt    = rp_dec;
            stop       = 1'b1;
            state_nxt  = ST_MLO;
          end
        end
        if (!stop) begin
          if (rp_r < count_r) begin
            rd_addr = rp_r[ADDR_W-1:0];
            rp_nxt  = rp_r + CNT_W'(1);
            dv_nxt  = 1'b1;
          end else begin
            dv_nxt = 1'b0;
            if (op_r == OP_ALLOC) begin
              status_nxt = STS_NOFIT;
              state_nxt  = ST_DONE;
            end else begin
              idx_nxt   = count_r;
              state_nxt = ST_MLO;
            end
          end
        end
      end

      ST_ALC: begin
        alu_in.a   = found_r.len;
        alu_in.b   = cnt_r;
        astart_nxt = found_r.start;
        if (alu_out.diff == '0) begin
          // Exact fit: the block leaves the table.
          free_total_nxt = tot_dec_r;
          rp_nxt         = idx_inc;
          wp_nxt         = idx_r;
          dv_nxt         = 1'b0;
          state_nxt      = ST_SHDN;
        end else begin
          len_new_nxt = alu_out.diff;
          state_nxt   = ST_ALC2;
        end
      end

      ST_ALC2: begin
        // The remainder keeps its slot; its start wraps to the page width.
        alu_in.a       = {1'b0, found_r.start};
        alu_in.b       = cnt_r;
        wr_en          = 1'b1;
        wr_addr        = idx_r[ADDR_W-1:0];
        wr_data.start  = alu_out.sum[START_W-1:0];
        wr_data.len    = len_new_r;
        free_total_nxt = tot_dec_r;
        state_nxt      = ST_DONE;
      end

      ST_MLO: begin
        alu_in.a  = lo_r.len;
        alu_in.b  = {1'b0, lo_r.start};
        alu_in.c  = base_r;
        mlo_nxt   = (op_r == OP_FREE) && has_lo_r && alu_out.eq;
        state_nxt = ST_MLEN;
      end

      ST_MLEN: begin
        alu_in.a = lo_r.len;
        alu_in.b = cnt_r;
        if (mlo_r) begin
          seg_start_nxt = lo_r.start;
          seg_len_nxt   = alu_out.sat;
        end else begin
          seg_start_nxt = base_r;
          seg_len_nxt   = cnt_r;
        end
        state_nxt = ST_MHI;
      end

      ST_MHI: begin
        alu_in.a  = seg_len_r;
        alu_in.b  = {1'b0, seg_start_r};
        alu_in.c  = hi_r.start;
        mhi_nxt   = (op_r == OP_FREE) && has_hi_r && alu_out.eq;
        state_nxt = ST_MHLEN;
      end

      ST_MHLEN: begin
        alu_in.a  = seg_len_r;
        alu_in.b  = hi_r.len;
        mlen_nxt  = alu_out.sat;
        state_nxt = ST_COMMIT;
      end

      ST_COMMIT: begin
        if (!mlo_r && !mhi_r) begin
          rp_nxt    = count_r;
          wp_nxt    = count_r;
          dv_nxt    = 1'b0;
          state_nxt = ST_SHUP;
        end else if (mlo_r && !mhi_r) begin
          wr_en         = 1'b1;
          wr_addr       = idx_dec[ADDR_W-1:0];
          wr_data.start = lo_r.start;
          wr_data.len   = seg_len_r;
          state_nxt     = ST_DONE;
        end else if (!mlo_r && mhi_r) begin
          wr_en         = 1'b1;
          wr_addr       = idx_r[ADDR_W-1:0];
          wr_data.start = base_r;
          wr_data.len   = mlen_r;
          state_nxt     = ST_DONE;
        end else begin
          // Both neighbors join; the upper one is removed afterwards.
          wr_en         = 1'b1;
          wr_addr       = idx_dec[ADDR_W-1:0];
          wr_data.start = lo_r.start;
          wr_data.len   = mlen_r;
          rp_nxt        = idx_inc;
          wp_nxt        = idx_r;
          dv_nxt        = 1'b0;
          state_nxt     = ST_SHDN;
        end
      end

      ST_SHUP: begin
        // Move the tail up one slot from the top down, then drop in the block.
        if (dv_r) begin
          wr_en   = 1'b1;
          wr_addr = wp_r[ADDR_W-1:0];
          wr_data = rd_data_r;
          wp_nxt  = wp_r - CNT_W'(1);
        end
        if (rp_r > idx_r) begin
          rd_addr = rp_dec[ADDR_W-1:0];
          rp_nxt  = rp_dec;
          dv_nxt  = 1'b1;
        end else begin
          dv_nxt = 1'b0;
          if (!dv_r) begin
            wr_en         = 1'b1;
            wr_addr       = idx_r[ADDR_W-1:0];
            wr_data.start = base_r;
            wr_data.len   = cnt_r;
            count_nxt     = count_r + CNT_W'(1);
            state_nxt     = ST_DONE;
          end
        end
      end

      ST_SHDN: begin
        // Move the tail down one slot from the bottom up.
        if (dv_r) begin
          wr_en   = 1'b1;
          wr_addr = wp_r[ADDR_W-1:0];
          wr_data = rd_data_r;
          wp_nxt  = wp_r + CNT_W'(1);
        end
        if (rp_r < count_r) begin
          rd_addr = rp_r[ADDR_W-1:0];
          rp_nxt  = rp_r + CNT_W'(1);
          dv_nxt  = 1'b1;
        end else begin
          dv_nxt    = 1'b0;
          count_nxt = count_r - CNT_W'(1);
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_status_nxt      = status_r;
          out_alloc_start_nxt = astart_r;
          out_free_total_nxt  = free_total_r;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      free_total_r <= '0;
      out_valid_r  <= 1'b0;
      dv_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      free_total_r <= free_total_nxt;
      out_valid_r  <= out_valid_nxt;
      dv_r         <= dv_nxt;
    end
    op_r              <= op_nxt;
    base_r            <= base_nxt;
    cnt_r             <= cnt_nxt;
    tot_dec_r         <= tot_dec_nxt;
    status_r          <= status_nxt;
    astart_r          <= astart_nxt;
    rp_r              <= rp_nxt;
    wp_r              <= wp_nxt;
    idx_r             <= idx_nxt;
    has_lo_r          <= has_lo_nxt;
    has_hi_r          <= has_hi_nxt;
    lo_r              <= lo_nxt;
    hi_r              <= hi_nxt;
    found_r           <= found_nxt;
    len_new_r         <= len_new_nxt;
    mlo_r             <= mlo_nxt;
    mhi_r             <= mhi_nxt;
    seg_start_r       <= seg_start_nxt;
    seg_len_r         <= seg_len_nxt;
    mlen_r            <= mlen_nxt;
    out_status_r      <= out_status_nxt;
    out_alloc_start_r <= out_alloc_start_nxt;
    out_free_total_r  <= out_free_total_nxt;
  end

  // Block table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  // An accepted item leaves the input not ready in the cycle after it is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted item");

  // Only a successful allocate reports a start page.
  a_fail_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STS_OK) |-> (out_alloc_start == '0))
    else $error("failed request reports a start page");

  // The table never holds more blocks than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BLOCKS))
    else $error("block count beyond table size");

  // One request changes the block count by at most one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNT_W'(1) || count_r == $past(count_r) - CNT_W'(1)))
    else $error("block count jumped");

  // The search never reads past the used part of the table.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rp_r <= count_r))
    else $error("search pointer past end of table");

endmodule

`default_nettype wire

@@ hw/rtl/ffpa_alu.sv @@
`default_nettype none

// Shared adder and subtractor. The sum is kept one bit wider so that
// adjacency tests see no wrap, and a saturated copy is offered as well.
module ffpa_alu (
  input  wire ffpa_pkg::ffpa_alu_in_t alu_in,
  output ffpa_pkg::ffpa_alu_out_t     alu_out
);
  import ffpa_pkg::*;

  logic [LEN_W:0] sum;
  logic [LEN_W:0] sub;

  assign sum = {1'b0, alu_in.a} + {1'b0, alu_in.b};
  assign sub = {1'b0, alu_in.a} - {1'b0, alu_in.b};

  assign alu_out.sum  = sum;
  assign alu_out.sat  = sum[LEN_W] ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
  assign alu_out.diff = sub[LEN_W-1:0];
  assign alu_out.ge   = ~sub[LEN_W];
  assign alu_out.eq   = (sum == {2'b00, alu_in.c});

endmodule

`default_nettype wire
